FILE: rtl/ssis_pkg.sv
// ----------------------------------------------------------------------------
// ssis_pkg: shared types for the sorted set insert/search core
// Operation codes, sequencer states and the compare result bundle.
// ----------------------------------------------------------------------------
package ssis_pkg;

  localparam int unsigned DataW = 32;
  localparam int unsigned CountOutW = 7;

  typedef enum logic {
    OP_INSERT = 1'b0,
    OP_QUERY  = 1'b1
  } op_e;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_RD,
    ST_CMP,
    ST_SH_RD,
    ST_SH_WR,
    ST_INS,
    ST_DONE
  } state_e;

  // result of the shared signed comparator
  typedef struct packed {
    logic lt;
    logic eq;
  } cmp_t;

endpackage

FILE: rtl/ssis_mem.sv
// ----------------------------------------------------------------------------
// ssis_mem: entry storage
// One write port, one read port with registered read data.
// ----------------------------------------------------------------------------
module ssis_mem
  import ssis_pkg::*;
#(
  parameter int unsigned Depth = 64,
  parameter int unsigned AddrW = 6
) (
  input  logic             clk_i,
  input  logic             we_i,
  input  logic [AddrW-1:0] waddr_i,
  input  logic [DataW-1:0] wdata_i,
  input  logic [AddrW-1:0] raddr_i,
  output logic [DataW-1:0] rdata_o
);

  logic [DataW-1:0] mem_q [Depth];
  logic [DataW-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
  end

  always_ff @(posedge clk_i) begin
    rdata_q <= mem_q[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

FILE: rtl/ssis_cmp.sv
// ----------------------------------------------------------------------------
// ssis_cmp: shared signed comparator
// Compares a stored entry against the request value.
// ----------------------------------------------------------------------------
module ssis_cmp
  import ssis_pkg::*;
(
  input  logic signed [DataW-1:0] entry_i,
  input  logic signed [DataW-1:0] key_i,
  output cmp_t                    cmp_o
);

  always_comb begin
    cmp_o.lt = entry_i < key_i;
    cmp_o.eq = entry_i == key_i;
  end

endmodule

FILE: rtl/sorted_set_insert_search_core.sv
// ----------------------------------------------------------------------------
// sorted_set_insert_search_core: sorted set of signed 32-bit values
// Binary search over an ascending entry memory; inserts shift larger
// entries up one place at a time through the same memory ports.
// ----------------------------------------------------------------------------
//
//  channel  | handshake         | payload
//  ---------+-------------------+-----------------------------------------
//  request  | start, busy       | operation_i, value_i
//  result   | done_o (1 cycle)  | found_o, dropped_full_o, entry_count_o
//
// A request runs S binary search steps, S <= ceil(log2(count+1)), each a
// memory read followed by a compare. An insert of a new value then moves
// M entries up, M = entries moved up, each move being one read and one
// write on the single memory port pair.
// Reset clears the count and the sequencer; entry contents are not cleared.
// busy is high from the accepting edge until the result strobe has passed.
// The receiver cannot stall: done_o is high for exactly one cycle.
//
module sorted_set_insert_search_core
  import ssis_pkg::*;
#(
  parameter int unsigned CAPACITY = 64
) (
  input  logic                    clk_i,
  input  logic                    rst_ni,
  input  logic                    start,
  output logic                    busy,
  input  logic                    operation_i,
  input  logic signed [DataW-1:0] value_i,
  output logic                    done_o,
  output logic                    found_o,
  output logic                    dropped_full_o,
  output logic [CountOutW-1:0]    entry_count_o
);

  localparam int unsigned AW  = $clog2(CAPACITY);
  localparam int unsigned CW  = $clog2(CAPACITY + 1);
  localparam int unsigned CXW = (CW > CountOutW) ? CW : CountOutW;

  state_e state_q, state_d;

  // request and search registers
  op_e              op_q;
  logic [DataW-1:0] value_q;
  logic [CW-1:0]    lo_q;      // search low bound, ends as insert place
  logic [CW-1:0]    hi_q;
  logic [CW-1:0]    idx_q;     // shift pointer (destination place)
  logic [CW-1:0]    count_q;
  logic             eq_q;      // entry at last "not less" probe matched
  logic             dropped_q;

  logic [CW-1:0]    mid;
  logic             search_on;
  logic             full;
  logic             do_shift;
  logic             accept;

  // memory and compare wiring
  logic             mem_we;
  logic [AW-1:0]    mem_waddr;
  logic [DataW-1:0] mem_wdata;
  logic [AW-1:0]    mem_raddr;
  logic [DataW-1:0] mem_rdata;
  cmp_t             cmp;
  logic [CXW-1:0]   count_ext;

  assign accept    = start && !busy;
  assign mid       = lo_q + ((hi_q - lo_q) >> 1);
  assign search_on = lo_q < hi_q;
  assign full      = count_q == CW'(CAPACITY);
  assign do_shift  = (op_q == OP_INSERT) && !eq_q && !full;

  ssis_mem #(
    .Depth (CAPACITY),
    .AddrW (AW)
  ) u_mem (
    .clk_i   (clk_i),
    .we_i    (mem_we),
    .waddr_i (mem_waddr),
    .wdata_i (mem_wdata),
    .raddr_i (mem_raddr),
    .rdata_o (mem_rdata)
  );

  ssis_cmp u_cmp (
    .entry_i (mem_rdata),
    .key_i   (value_q),
    .cmp_o   (cmp)
  );

  // next state
  always_comb begin
    state_d = state_q;
    case (state_q)
      ST_IDLE: begin
        if (accept) state_d = ST_RD;
      end
      ST_RD: begin
        if (search_on)     state_d = ST_CMP;
        else if (do_shift) state_d = ST_SH_RD;
        else               state_d = ST_DONE;
      end
      ST_CMP:   state_d = ST_RD;
      ST_SH_RD: begin
        if (idx_q > lo_q) state_d = ST_SH_WR;
        else              state_d = ST_INS;
      end
      ST_SH_WR: state_d = ST_SH_RD;
      ST_INS:   state_d = ST_DONE;
      ST_DONE:  state_d = ST_IDLE;
      default:  state_d = ST_IDLE;
    endcase
  end

  // memory port control and strobes
  always_comb begin
    mem_we    = 1'b0;
    mem_waddr = idx_q[AW-1:0];
    mem_wdata = mem_rdata;
    mem_raddr = mid[AW-1:0];
    done_o    = 1'b0;
    case (state_q)
      ST_SH_RD: mem_raddr = AW'(idx_q - CW'(1));
      ST_SH_WR: mem_we = 1'b1;
      ST_INS: begin
        mem_we    = 1'b1;
        mem_waddr = lo_q[AW-1:0];
        mem_wdata = value_q;
      end
      ST_DONE:  done_o = 1'b1;
      default: ;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
      count_q <= '0;
    end else begin
      state_q <= state_d;
      if (state_q == ST_INS) count_q <= count_q + CW'(1);
    end
  end

  // datapath registers
  always_ff @(posedge clk_i) begin
    case (state_q)
      ST_IDLE: begin
        if (accept) begin
          op_q      <= op_e'(operation_i);
          value_q   <= value_i;
          lo_q      <= '0;
          hi_q      <= count_q;
          idx_q     <= count_q;
          eq_q      <= 1'b0;
          dropped_q <= 1'b0;
        end
      end
      ST_RD: begin
        if (!search_on) dropped_q <= (op_q == OP_INSERT) && !eq_q && full;
      end
      ST_CMP: begin
        if (cmp.lt) begin
          lo_q <= mid + CW'(1);
        end else begin
          hi_q <= mid;
          eq_q <= cmp.eq;
        end
      end
      ST_SH_WR: idx_q <= idx_q - CW'(1);
      default: ;
    endcase
  end

  assign busy           = state_q != ST_IDLE;
  assign found_o        = eq_q;
  assign dropped_full_o = dropped_q;
  assign count_ext      = CXW'(count_q);
  assign entry_count_o  = count_ext[CountOutW-1:0];

`ifndef SYNTH
  a_count_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    count_q <= CW'(CAPACITY))
    else $error("entry count above capacity");

  a_drop_excl: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o |-> !(found_o && dropped_full_o))
    else $error("result both found and dropped");

  a_drop_full: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (done_o && dropped_full_o) |-> full)
    else $error("drop reported on a set that is not full");

  a_count_grow: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_INS) |=> (count_q == $past(count_q) + CW'(1)))
    else $error("insert did not grow the count by one");
`endif

endmodule
